>>> rtl/core/tbsm_pkg.sv
// ---------------------------------------------------------------------------
// tbsm_pkg - shared types and constants
// Register indexes, item and limit codes, value limits and reset values
// for the two-button settings menu.
// ---------------------------------------------------------------------------
package tbsm_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int REQ_DATA_WIDTH  = 8;
   localparam int RSP_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EXIT_HOLD     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ENTRY_HOLDOFF = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EXIT_HOLDOFF  = 2'd2;

   localparam logic [7:0] EXIT_HOLD_RESET     = 8'd10;
   localparam logic [7:0] ENTRY_HOLDOFF_RESET = 8'd10;
   localparam logic [7:0] EXIT_HOLDOFF_RESET  = 8'd20;

   localparam logic [1:0] ITEM_HALT  = 2'd0;
   localparam logic [1:0] ITEM_ANGLE = 2'd1;
   localparam logic [1:0] ITEM_REST  = 2'd2;

   localparam logic [1:0] LIMIT_NONE = 2'd0;
   localparam logic [1:0] LIMIT_LOW  = 2'd1;
   localparam logic [1:0] LIMIT_HIGH = 2'd2;

   localparam logic [10:0] HALT_MIN   = 11'd100;
   localparam logic [10:0] HALT_MAX   = 11'd2000;
   localparam logic [10:0] HALT_STEP  = 11'd100;
   localparam logic [10:0] HALT_RESET = 11'd1000;

   localparam logic [6:0] ANGLE_MIN   = 7'd10;
   localparam logic [6:0] ANGLE_MAX   = 7'd70;
   localparam logic [6:0] ANGLE_STEP  = 7'd5;
   localparam logic [6:0] ANGLE_RESET = 7'd45;

   localparam logic [8:0] REST_MARGIN    = 9'd10;
   localparam logic [8:0] REST_SPAN_HIGH = 9'd170;
   localparam logic [7:0] REST_STEP      = 8'd5;
   localparam logic [7:0] REST_RESET     = 8'd90;

   typedef struct packed {
      logic [10:0] halt;
      logic [6:0]  angle;
      logic [7:0]  rest;
   } settings_type;

endpackage

>>> rtl/core/tbsm_adjust.sv
// ---------------------------------------------------------------------------
// tbsm_adjust - one edit step on the selected setting
// Applies a decrease then an increase to the selected value, each only
// while the value is inside its limits, and reports a refused step.
// ---------------------------------------------------------------------------
module tbsm_adjust
   import tbsm_pkg::*;
(
   input  logic [1:0]   sel,
   input  logic         down,
   input  logic         up,
   input  settings_type cur,
   output settings_type nxt,
   output logic [1:0]   hit
);

   settings_type mid;

   always_comb begin
      mid = cur;
      nxt = cur;
      hit = LIMIT_NONE;
      if (down) begin
         case (sel)
            ITEM_HALT: begin
               if (cur.halt > HALT_MIN) mid.halt = cur.halt - HALT_STEP;
               else hit = LIMIT_LOW;
            end
            ITEM_ANGLE: begin
               if (cur.angle > ANGLE_MIN) mid.angle = cur.angle - ANGLE_STEP;
               else hit = LIMIT_LOW;
            end
            default: begin
               if ({1'b0, cur.rest} > REST_MARGIN + {2'b0, cur.angle})
                  mid.rest = cur.rest - REST_STEP;
               else hit = LIMIT_LOW;
            end
         endcase
      end
      nxt = mid;
      // increase sees the value left by the decrease
      if (up) begin
         case (sel)
            ITEM_HALT: begin
               if (mid.halt < HALT_MAX) nxt.halt = mid.halt + HALT_STEP;
               else hit = LIMIT_HIGH;
            end
            ITEM_ANGLE: begin
               if (mid.angle < ANGLE_MAX) nxt.angle = mid.angle + ANGLE_STEP;
               else hit = LIMIT_HIGH;
            end
            default: begin
               if ({1'b0, mid.rest} + {2'b0, mid.angle} < REST_SPAN_HIGH)
                  nxt.rest = mid.rest + REST_STEP;
               else hit = LIMIT_HIGH;
            end
         endcase
      end
   end

endmodule

>>> rtl/core/two_button_settings_menu.sv
// ---------------------------------------------------------------------------
// two_button_settings_menu - settings menu driven by two buttons
// Takes one button sample per request and returns the menu state after it.
//
// req_ carries one sample of both button levels. Each accepted request
// gives exactly one response on rsp_ with the selected item, the edit flag,
// the three settings and a limit code for a refused step.
// The response is registered in the response register, or in the skid
// register while the receiver stalls. A request can be accepted every cycle
// while the skid entry is empty; the menu state and the response or skid register update in the same edge.
// A two-entry output (response register plus skid register) keeps req_tready
// a plain register output: a stalled receiver fills the skid entry and only
// then is req_tready dropped, until the receiver drains it.
// Reset clears the menu to item 0, out of edit mode, settings at 1000 ms,
// 45 and 90 degrees, the first sample only loading the button levels, and
// the csr_ registers to their defaults. Write csr_ only while idle.
// ---------------------------------------------------------------------------
module two_button_settings_menu
   import tbsm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [0] button_one, [1] button_two, [7:2] zero
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [1:0] menu_item, [2] editing, [13:3] halt_time_ms, [20:14] separation_deg,
   // [28:21] rest_deg, [30:29] limit_hit, [31] zero
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   // configuration
   logic [7:0] exit_hold_ff, entry_holdoff_ff, exit_holdoff_ff;

   // menu state
   logic [1:0]   item_ff, item_in;
   logic         edit_ff, edit_in;
   logic [1:0]   prev_ff, prev_in;
   logic         resync_ff, resync_in;
   logic [7:0]   hold_ff, hold_in;
   logic [7:0]   holdoff_ff, holdoff_in;
   settings_type set_ff, set_in;

   // output stage
   logic                      out_valid_ff, skid_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] out_data_ff, skid_data_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_word;

   logic       push, pop;
   logic       b1, b2;
   logic       fall1, fall2;
   logic       process, edit_step;
   logic       adj_down, adj_up;
   logic [1:0] adj_hit, hit;
   logic [7:0] hold_step, need;
   settings_type adj_set;

   assign req_tready = !skid_valid_ff;
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   assign b1 = req_tdata[0];
   assign b2 = req_tdata[1];

   assign process   = (holdoff_ff == 8'd0) && !resync_ff;
   assign edit_step = process && edit_ff;
   assign fall1     = prev_ff[0] && !b1;
   assign fall2     = prev_ff[1] && !b2;
   assign adj_down  = edit_step && fall1 && !b2;
   assign adj_up    = edit_step && fall2 && !b1;
   assign need      = (exit_hold_ff == 8'd0) ? 8'd1 : exit_hold_ff;

   tbsm_adjust u_adjust (
      .sel  (item_ff),
      .down (adj_down),
      .up   (adj_up),
      .cur  (set_ff),
      .nxt  (adj_set),
      .hit  (adj_hit)
   );

   always_comb begin
      hold_step = hold_ff;
      if (fall1 || fall2) hold_step = 8'd0;
      if ((b1 || b2) && hold_step != 8'hFF) hold_step = hold_step + 8'd1;
   end

   always_comb begin
      item_in    = item_ff;
      edit_in    = edit_ff;
      prev_in    = prev_ff;
      resync_in  = resync_ff;
      hold_in    = hold_ff;
      holdoff_in = holdoff_ff;
      set_in     = set_ff;
      hit        = LIMIT_NONE;
      if (holdoff_ff != 8'd0) begin
         holdoff_in = holdoff_ff - 8'd1;
      end else if (resync_ff) begin
         prev_in   = {b2, b1};
         resync_in = 1'b0;
      end else begin
         prev_in = {b2, b1};
         if (!edit_ff) begin
            if (fall1 && !b2) item_in = (item_ff >= ITEM_REST) ? ITEM_HALT : item_ff + 2'd1;
            if (!b1 && fall2) begin
               edit_in    = 1'b1;
               hold_in    = 8'd0;
               holdoff_in = (entry_holdoff_ff == 8'd0) ? 8'd0 : entry_holdoff_ff - 8'd1;
               resync_in  = 1'b1;
            end
         end else begin
            set_in  = adj_set;
            hit     = adj_hit;
            hold_in = hold_step;
            if (hold_step >= need) begin
               edit_in    = 1'b0;
               hold_in    = 8'd0;
               prev_in    = 2'b00;
               holdoff_in = exit_holdoff_ff;
            end
         end
      end
   end

   assign rsp_word = {1'b0, hit, set_in.rest, set_in.angle, set_in.halt, edit_in, item_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         exit_hold_ff     <= EXIT_HOLD_RESET;
         entry_holdoff_ff <= ENTRY_HOLDOFF_RESET;
         exit_holdoff_ff  <= EXIT_HOLDOFF_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_EXIT_HOLD:     exit_hold_ff     <= csr_data;
            REG_ENTRY_HOLDOFF: entry_holdoff_ff <= csr_data;
            REG_EXIT_HOLDOFF:  exit_holdoff_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff    <= ITEM_HALT;
         edit_ff    <= 1'b0;
         prev_ff    <= 2'b00;
         resync_ff  <= 1'b1;
         hold_ff    <= 8'd0;
         holdoff_ff <= 8'd0;
         set_ff     <= '{halt: HALT_RESET, angle: ANGLE_RESET, rest: REST_RESET};
      end else if (push) begin
         item_ff    <= item_in;
         edit_ff    <= edit_in;
         prev_ff    <= prev_in;
         resync_ff  <= resync_in;
         hold_ff    <= hold_in;
         holdoff_ff <= holdoff_in;
         set_ff     <= set_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (!out_valid_ff) begin
         out_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end else if (push && (pop || !out_valid_ff)) begin
         out_data_ff <= rsp_word;
      end
      if (push && out_valid_ff && !pop) begin
         skid_data_ff <= rsp_word;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // skid entry is only ever filled behind a waiting response
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without a response");

   // hold counting only happens in edit mode
   a_hold_in_edit: assert property (@(posedge clock) disable iff (reset)
      (hold_ff != 8'd0) |-> edit_ff)
      else $error("hold count set outside edit mode");

   // an ignored sample only counts the hold-off down
   a_holdoff_count: assert property (@(posedge clock) disable iff (reset)
      (push && holdoff_ff != 8'd0) |=> (holdoff_ff == $past(holdoff_ff) - 8'd1)
         && $stable(set_ff) && $stable(item_ff))
      else $error("ignored sample changed the menu");

   // halt time stays on its range
   a_halt_range: assert property (@(posedge clock) disable iff (reset)
      (set_ff.halt >= HALT_MIN) && (set_ff.halt <= HALT_MAX))
      else $error("halt time out of range");

endmodule
